### rtl/core/fan_servo_command_controller_defines.svh
// Assertion macros for the RTL that carries checks.
`ifndef FAN_SERVO_COMMAND_CONTROLLER_DEFINES_SVH
`define FAN_SERVO_COMMAND_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define FSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define FSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fsc_pkg.sv
`default_nettype none

package fsc_pkg;

    localparam int SERVO_W = 10;
    localparam int DUTY_W  = 11;
    localparam int CMD_W   = 8;
    localparam int STAT_W  = 2;
    localparam int LED_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    // Angle offset (0..160) times the servo span magnitude (0..1023).
    localparam int PROD_W = 18;

    // Division by 160 is a shift by 5 followed by a reciprocal multiply for 5.
    localparam int DIV_SHIFT   = 5;
    localparam int QUO_IN_W    = PROD_W - DIV_SHIFT;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_PROD_W = QUO_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;

    localparam logic [CMD_W-1:0] CMD_STOP     = 8'd200;
    localparam logic [CMD_W-1:0] CMD_START    = 8'd255;
    localparam logic [CMD_W-1:0] CMD_ANGLE_LO = 8'd10;
    localparam logic [CMD_W-1:0] CMD_ANGLE_HI = 8'd170;

    localparam logic [STAT_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_READY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RUN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_HOME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SLOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FAST  = 3'd5;

    localparam logic [SERVO_W-1:0] RST_SERVO_LOW  = 10'd140;
    localparam logic [SERVO_W-1:0] RST_SERVO_HIGH = 10'd610;
    localparam logic [SERVO_W-1:0] RST_SERVO_HOME = 10'd375;
    localparam logic [DUTY_W-1:0]  RST_DUTY_SLOW  = 11'd1199;
    localparam logic [DUTY_W-1:0]  RST_DUTY_MID   = 11'd799;
    localparam logic [DUTY_W-1:0]  RST_DUTY_FAST  = 11'd399;

    localparam logic [1:0] STEP_SLOW = 2'd0;
    localparam logic [1:0] STEP_MID  = 2'd1;
    localparam logic [1:0] STEP_FAST = 2'd2;

    // Accepted item as held in the input register.
    typedef struct packed {
        logic              kind;
        logic [CMD_W-1:0]  cmd;
        logic              toggle;
        logic              speed;
        logic [PROD_W-1:0] prod;
        logic              span_neg;
    } item_t;

endpackage

`default_nettype wire

### rtl/core/fsc_angle_map.sv
`default_nettype none

module fsc_angle_map (
    input  wire logic [fsc_pkg::PROD_W-1:0]  prod,
    input  wire logic                        span_neg,
    input  wire logic [fsc_pkg::SERVO_W-1:0] servo_low,
    output logic      [fsc_pkg::SERVO_W-1:0] goal
);
    import fsc_pkg::*;

    logic [QUO_IN_W-1:0]     quo_in;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [SERVO_W-1:0]      quo;

    // floor(p / 160) == floor(floor(p / 32) / 5); the reciprocal is exact
    // for every value below 2^18, so no correction step is needed.
    assign quo_in     = prod[PROD_W-1:DIV_SHIFT];
    assign recip_prod = RECIP_PROD_W'(quo_in) * RECIP_PROD_W'(RECIP_5);
    assign quo        = recip_prod[RECIP_SHIFT+SERVO_W-1:RECIP_SHIFT];

    // The magnitude was divided, so the quotient truncates toward zero.
    assign goal = span_neg ? (servo_low - quo) : (servo_low + quo);

endmodule

`default_nettype wire

### rtl/core/fan_servo_command_controller.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    kind, command_byte, toggle_button, speed_button
// m_        out        m_valid / m_ready    status, servo_position, fan_enabled,
//                                           fan_duty, led_bar
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One item per cycle while m_ready is high; results load from the input register.
// The angle product is formed as the item enters the input register; the divide
// by 160 and the state update happen between the input and result registers.
// A stalled result holds the result register; the input register still takes
// one more item, and s_ready drops only when both are full and m_ready is low.
// Reset (synchronous, active low) restores config, state and valid flags, not data.
`default_nettype none
`include "fan_servo_command_controller_defines.svh"

module fan_servo_command_controller (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [fsc_pkg::CMD_W-1:0]      s_command_byte,
    input  wire logic                           s_toggle_button,
    input  wire logic                           s_speed_button,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [fsc_pkg::STAT_W-1:0]     m_status,
    output logic      [fsc_pkg::SERVO_W-1:0]    m_servo_position,
    output logic                                m_fan_enabled,
    output logic      [fsc_pkg::DUTY_W-1:0]     m_fan_duty,
    output logic      [fsc_pkg::LED_W-1:0]      m_led_bar,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fsc_pkg::*;

    // Configuration registers.
    logic [SERVO_W-1:0] servo_low_reg, servo_high_reg, servo_home_reg;
    logic [DUTY_W-1:0]  duty_slow_reg, duty_mid_reg, duty_fast_reg;

    // Controller state.
    logic               fan_running_reg, fan_running_next;
    logic [1:0]         speed_step_reg, speed_step_next;
    logic               user_ready_reg, user_ready_next;
    logic               homing_pending_reg, homing_pending_next;
    logic [SERVO_W-1:0] servo_now_reg, servo_now_next;
    logic [SERVO_W-1:0] servo_goal_reg, servo_goal_next;
    logic [STAT_W-1:0]  status_code_reg, status_code_next;
    logic               toggle_was_reg, toggle_was_next;
    logic               speed_was_reg, speed_was_next;

    // Pipeline.
    item_t              st1_reg, st1_next;
    logic               st1_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               fire;

    logic [STAT_W-1:0]  m_status_reg;
    logic [SERVO_W-1:0] m_servo_reg;
    logic               m_fan_reg;
    logic [DUTY_W-1:0]  m_duty_reg, duty_next;
    logic [LED_W-1:0]   m_led_reg, led_next;

    logic signed [SERVO_W:0] span;
    logic [SERVO_W-1:0]      span_abs;
    logic [CMD_W-1:0]        angle_off;
    logic [SERVO_W-1:0]      mapped_goal;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = st1_valid_reg && advance;
    assign s_ready   = !st1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Angle product depends only on the byte and configuration, so it is
    // formed on the way into the input register.
    assign span      = $signed({1'b0, servo_high_reg}) - $signed({1'b0, servo_low_reg});
    assign span_abs  = span[SERVO_W] ? SERVO_W'(-span) : SERVO_W'(span);
    assign angle_off = s_command_byte - CMD_ANGLE_LO;

    always_comb begin
        st1_next.kind     = s_kind;
        st1_next.cmd      = s_command_byte;
        st1_next.toggle   = s_toggle_button;
        st1_next.speed    = s_speed_button;
        st1_next.prod     = PROD_W'(angle_off) * PROD_W'(span_abs);
        st1_next.span_neg = span[SERVO_W];
    end

    fsc_angle_map u_angle_map (
        .prod      (st1_reg.prod),
        .span_neg  (st1_reg.span_neg),
        .servo_low (servo_low_reg),
        .goal      (mapped_goal)
    );

    always_comb begin
        fan_running_next    = fan_running_reg;
        speed_step_next     = speed_step_reg;
        user_ready_next     = user_ready_reg;
        homing_pending_next = homing_pending_reg;
        servo_now_next      = servo_now_reg;
        servo_goal_next     = servo_goal_reg;
        status_code_next    = status_code_reg;
        toggle_was_next     = toggle_was_reg;
        speed_was_next      = speed_was_reg;

        if (st1_reg.kind) begin
            if (st1_reg.toggle && !toggle_was_reg) begin
                homing_pending_next = 1'b1;
                if (user_ready_reg) begin
                    user_ready_next  = 1'b0;
                    fan_running_next = 1'b0;
                    speed_step_next  = STEP_SLOW;
                end else begin
                    user_ready_next = 1'b1;
                    servo_goal_next = servo_home_reg;
                end
            end
            toggle_was_next = st1_reg.toggle;

            if (fan_running_next) begin
                // The speed button is tracked only while the fan runs.
                if (st1_reg.speed && !speed_was_reg) begin
                    speed_step_next = (speed_step_next >= STEP_FAST) ? STEP_SLOW
                                                                     : speed_step_next + 2'd1;
                end
                speed_was_next = st1_reg.speed;
                if (servo_now_reg < servo_goal_next) begin
                    servo_now_next = servo_now_reg + 1'b1;
                end else if (servo_now_reg > servo_goal_next) begin
                    servo_now_next = servo_now_reg - 1'b1;
                end
                status_code_next = ST_RUN;
            end else begin
                if (homing_pending_next || user_ready_next) begin
                    if (servo_now_reg == servo_home_reg) begin
                        homing_pending_next = 1'b0;
                    end else if (servo_now_reg < servo_home_reg) begin
                        servo_now_next = servo_now_reg + 1'b1;
                    end else begin
                        servo_now_next = servo_now_reg - 1'b1;
                    end
                end
                status_code_next = (user_ready_next && servo_now_next == servo_home_reg)
                                   ? ST_READY : ST_IDLE;
            end
        end else begin
            if (st1_reg.cmd == CMD_STOP) begin
                fan_running_next    = 1'b0;
                speed_step_next     = STEP_SLOW;
                user_ready_next     = 1'b0;
                homing_pending_next = 1'b1;
            end else if (st1_reg.cmd >= CMD_ANGLE_LO && st1_reg.cmd <= CMD_ANGLE_HI) begin
                if (user_ready_reg && fan_running_reg) begin
                    servo_goal_next = mapped_goal;
                end
            end else if (st1_reg.cmd == CMD_START) begin
                if (status_code_reg == ST_READY) begin
                    fan_running_next = 1'b1;
                    speed_step_next  = STEP_SLOW;
                end
            end
        end
    end

    always_comb begin
        duty_next = '0;
        led_next  = '0;
        if (fan_running_next) begin
            case (speed_step_next)
                STEP_MID: begin
                    duty_next = duty_mid_reg;
                    led_next  = 3'b011;
                end
                STEP_FAST: begin
                    duty_next = duty_fast_reg;
                    led_next  = 3'b111;
                end
                default: begin
                    duty_next = duty_slow_reg;
                    led_next  = 3'b001;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_low_reg  <= RST_SERVO_LOW;
            servo_high_reg <= RST_SERVO_HIGH;
            servo_home_reg <= RST_SERVO_HOME;
            duty_slow_reg  <= RST_DUTY_SLOW;
            duty_mid_reg   <= RST_DUTY_MID;
            duty_fast_reg  <= RST_DUTY_FAST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SERVO_LOW:  servo_low_reg  <= cfg_data[SERVO_W-1:0];
                CFG_SERVO_HIGH: servo_high_reg <= cfg_data[SERVO_W-1:0];
                CFG_SERVO_HOME: servo_home_reg <= cfg_data[SERVO_W-1:0];
                CFG_DUTY_SLOW:  duty_slow_reg  <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_MID:   duty_mid_reg   <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_FAST:  duty_fast_reg  <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_running_reg    <= 1'b0;
            speed_step_reg     <= STEP_SLOW;
            user_ready_reg     <= 1'b0;
            homing_pending_reg <= 1'b0;
            servo_now_reg      <= RST_SERVO_HOME;
            servo_goal_reg     <= RST_SERVO_HOME;
            status_code_reg    <= ST_IDLE;
            toggle_was_reg     <= 1'b0;
            speed_was_reg      <= 1'b0;
        end else if (fire) begin
            fan_running_reg    <= fan_running_next;
            speed_step_reg     <= speed_step_next;
            user_ready_reg     <= user_ready_next;
            homing_pending_reg <= homing_pending_next;
            servo_now_reg      <= servo_now_next;
            servo_goal_reg     <= servo_goal_next;
            status_code_reg    <= status_code_next;
            toggle_was_reg     <= toggle_was_next;
            speed_was_reg      <= speed_was_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                st1_valid_reg <= 1'b1;
            end else if (fire) begin
                st1_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            st1_reg <= st1_next;
        end
        if (fire) begin
            m_status_reg <= status_code_next;
            m_servo_reg  <= servo_now_next;
            m_fan_reg    <= fan_running_next;
            m_duty_reg   <= duty_next;
            m_led_reg    <= led_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = m_status_reg;
    assign m_servo_position = m_servo_reg;
    assign m_fan_enabled    = m_fan_reg;
    assign m_fan_duty       = m_duty_reg;
    assign m_led_bar        = m_led_reg;

    `FSC_ASSERT_NOW(a_stopped_outputs_zero, aclk, aresetn,
        out_valid_reg && !m_fan_reg, m_duty_reg == '0 && m_led_reg == '0,
        "stopped fan shows duty or LEDs")
    `FSC_ASSERT_NOW(a_backpressure_full, aclk, aresetn,
        !s_ready, st1_valid_reg && out_valid_reg && !m_ready,
        "input stalled while a stage is free")
    `FSC_ASSERT_NEXT(a_servo_moves_on_fire, aclk, aresetn,
        !fire, $stable(servo_now_reg),
        "servo position changed without an item")

endmodule

`default_nettype wire

### bench/fan_servo_command_controller_test.sv
`default_nettype none

module fan_servo_command_controller_test;
    import fsc_pkg::*;

    localparam int ANGLE_SPAN = 160;
    localparam int LONG_HOLD = 60;
    localparam int HOLD_AFTER_ITEMS = 120;
    localparam int STALL_LIMIT = 2000;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum {FLOW_OPEN, FLOW_RANDOM, FLOW_PERIODIC} flow_mode_t;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [SERVO_W-1:0] position;
        logic               fan_on;
        logic [DUTY_W-1:0]  duty;
        logic [LED_W-1:0]   leds;
    } reply_t;

    // Tracks the controller state and the replies still owed by the block.
    class reply_board_t;
        logic [SERVO_W-1:0] servo_low, servo_high, servo_home;
        logic [DUTY_W-1:0]  duty_slow, duty_mid, duty_fast;
        logic               fan_running, user_ready, homing_pending;
        logic               toggle_was_pressed, speed_was_pressed;
        logic [1:0]         speed_step;
        logic [SERVO_W-1:0] servo_now, servo_goal;
        logic [STAT_W-1:0]  status_code;
        reply_t             pending_replies[$];
        int                 mismatches;

        function new();
            servo_low = RST_SERVO_LOW;
            servo_high = RST_SERVO_HIGH;
            servo_home = RST_SERVO_HOME;
            duty_slow = RST_DUTY_SLOW;
            duty_mid = RST_DUTY_MID;
            duty_fast = RST_DUTY_FAST;
            fan_running = 1'b0;
            user_ready = 1'b0;
            homing_pending = 1'b0;
            toggle_was_pressed = 1'b0;
            speed_was_pressed = 1'b0;
            speed_step = STEP_SLOW;
            servo_now = RST_SERVO_HOME;
            servo_goal = RST_SERVO_HOME;
            status_code = ST_IDLE;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SERVO_LOW: servo_low = data[SERVO_W-1:0];
                CFG_SERVO_HIGH: servo_high = data[SERVO_W-1:0];
                CFG_SERVO_HOME: servo_home = data[SERVO_W-1:0];
                CFG_DUTY_SLOW: duty_slow = data[DUTY_W-1:0];
                CFG_DUTY_MID: duty_mid = data[DUTY_W-1:0];
                CFG_DUTY_FAST: duty_fast = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SERVO_W-1:0] nudge(logic [SERVO_W-1:0] now,
                                           logic [SERVO_W-1:0] goal);
            if (now < goal)
                return now + 10'd1;
            if (now > goal)
                return now - 10'd1;
            return now;
        endfunction

        function void take_item(logic kind, logic [CMD_W-1:0] cmd, logic tog, logic spd);
            int span;
            int scaled;
            reply_t want;
            if (kind == KIND_TICK) begin
                if (tog) begin
                    if (!toggle_was_pressed) begin
                        if (user_ready) begin
                            user_ready = 1'b0;
                            fan_running = 1'b0;
                            speed_step = STEP_SLOW;
                        end else begin
                            user_ready = 1'b1;
                            servo_goal = servo_home;
                        end
                        homing_pending = 1'b1;
                    end
                    toggle_was_pressed = 1'b1;
                end else begin
                    toggle_was_pressed = 1'b0;
                end
                if (fan_running) begin
                    if (spd) begin
                        if (!speed_was_pressed)
                            speed_step = (speed_step >= STEP_FAST) ? STEP_SLOW
                                                                   : speed_step + 2'd1;
                        speed_was_pressed = 1'b1;
                    end else begin
                        speed_was_pressed = 1'b0;
                    end
                    servo_now = nudge(servo_now, servo_goal);
                    status_code = ST_RUN;
                end else begin
                    // The speed level is frozen while the fan is stopped.
                    if (homing_pending || user_ready) begin
                        if (servo_now == servo_home)
                            homing_pending = 1'b0;
                        else
                            servo_now = nudge(servo_now, servo_home);
                    end
                    status_code = (user_ready && servo_now == servo_home) ? ST_READY : ST_IDLE;
                end
            end else if (cmd == CMD_STOP) begin
                fan_running = 1'b0;
                speed_step = STEP_SLOW;
                user_ready = 1'b0;
                homing_pending = 1'b1;
            end else if (cmd >= CMD_ANGLE_LO && cmd <= CMD_ANGLE_HI) begin
                if (user_ready && fan_running) begin
                    // Signed span so that a reversed range still maps between its ends.
                    span = int'(servo_high) - int'(servo_low);
                    scaled = (int'(cmd) - int'(CMD_ANGLE_LO)) * span / ANGLE_SPAN
                             + int'(servo_low);
                    servo_goal = scaled[SERVO_W-1:0];
                end
            end else if (cmd == CMD_START) begin
                if (status_code == ST_READY) begin
                    fan_running = 1'b1;
                    speed_step = STEP_SLOW;
                end
            end

            want.status = status_code;
            want.position = servo_now;
            want.fan_on = fan_running;
            want.duty = '0;
            want.leds = '0;
            if (fan_running) begin
                case (speed_step)
                    STEP_MID: want.duty = duty_mid;
                    STEP_FAST: want.duty = duty_fast;
                    default: want.duty = duty_slow;
                endcase
                want.leds = {speed_step == STEP_FAST,
                             speed_step == STEP_MID || speed_step == STEP_FAST, 1'b1};
            end
            pending_replies.push_back(want);
        endfunction

        task report(string what, int want, int got);
            if (mismatches < 40)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        endtask

        task check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                report("unexpected item", 0, 1);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.position !== want.position)
                report("servo_position", want.position, got.position);
            if (got.fan_on !== want.fan_on)
                report("fan_enabled", want.fan_on, got.fan_on);
            if (got.duty !== want.duty)
                report("fan_duty", want.duty, got.duty);
            if (got.leds !== want.leds)
                report("led_bar", want.leds, got.leds);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = KIND_COMMAND;
    logic [CMD_W-1:0]   s_command_byte = '0;
    logic               s_toggle_button = 1'b0;
    logic               s_speed_button = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic [SERVO_W-1:0] m_servo_position;
    logic               m_fan_enabled;
    logic [DUTY_W-1:0]  m_fan_duty;
    logic [LED_W-1:0]   m_led_bar;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    reply_board_t board = new();

    int   items_taken = 0;
    int   burst_left = 0;
    int   quiet_cycles = 0;
    logic held_off = 1'b0;
    logic toggle_level = 1'b0;
    logic spd_btn_level = 1'b0;

    fan_servo_command_controller i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_command_byte  (s_command_byte),
        .s_toggle_button (s_toggle_button),
        .s_speed_button  (s_speed_button),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_servo_position(m_servo_position),
        .m_fan_enabled   (m_fan_enabled),
        .m_fan_duty      (m_fan_duty),
        .m_led_bar       (m_led_bar),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_reply('{m_status, m_servo_position, m_fan_enabled,
                                m_fan_duty, m_led_bar});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: changing stall patterns, plus one long hold-off to back up the block.
    initial begin
        flow_mode_t mode;
        int mode_left;
        int beat;
        mode = FLOW_OPEN;
        mode_left = 0;
        beat = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_off && items_taken >= HOLD_AFTER_ITEMS) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = flow_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                beat++;
                case (mode)
                    FLOW_OPEN: m_ready <= 1'b1;
                    FLOW_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
                    default: m_ready <= ((beat % 5) < 3);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [CMD_W-1:0] cmd,
                             input logic tog, input logic spd);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_kind <= kind;
        s_command_byte <= cmd;
        s_toggle_button <= tog;
        s_speed_button <= spd;
        do @(posedge aclk); while (!s_ready);
        board.take_item(kind, cmd, tog, spd);
        items_taken++;
    endtask

    // Button levels are don't-care on commands and the byte on ticks, so both are randomized.
    task automatic command(input logic [CMD_W-1:0] cmd);
        send_item(KIND_COMMAND, cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic tick(input logic tog, input logic spd);
        send_item(KIND_TICK, 8'($urandom_range(0, 255)), tog, spd);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input int low, input int high, input int home,
                             input int slow, input int mid, input int fast);
        write_register(CFG_SERVO_LOW, 11'(low));
        write_register(CFG_SERVO_HIGH, 11'(high));
        write_register(CFG_SERVO_HOME, 11'(home));
        write_register(CFG_DUTY_SLOW, 11'(slow));
        write_register(CFG_DUTY_MID, 11'(mid));
        write_register(CFG_DUTY_FAST, 11'(fast));
    endtask

    task automatic wait_for_replies();
        s_valid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Sessions come out of the weights: press toggle, start when ready, run with
    // angles and speed presses, then stop or toggle off and let the servo home.
    task automatic run_random(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (board.fan_running) begin
                if (pick < 30) begin
                    command(8'($urandom_range(CMD_ANGLE_LO, CMD_ANGLE_HI)));
                end else if (pick < 33) begin
                    command(CMD_STOP);
                end else if (pick < 38) begin
                    command(8'($urandom_range(0, 255)));
                end else begin
                    if ($urandom_range(0, 39) == 0)
                        toggle_level = !toggle_level;
                    if ($urandom_range(0, 2) == 0)
                        spd_btn_level = !spd_btn_level;
                    tick(toggle_level, spd_btn_level);
                end
            end else if (board.status_code == ST_READY && pick < 40) begin
                command(CMD_START);
            end else if (pick < 10) begin
                command(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, board.user_ready ? 29 : 3) == 0)
                    toggle_level = !toggle_level;
                if ($urandom_range(0, 2) == 0)
                    spd_btn_level = !spd_btn_level;
                tick(toggle_level, spd_btn_level);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Nothing may happen before the system is switched on.
        command(8'd0);
        command(CMD_START);
        command(CMD_ANGLE_LO);
        // The speed press here is ignored and its level is not remembered.
        tick(1'b1, 1'b1);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        command(CMD_START);
        tick(1'b0, 1'b1);
        command(CMD_ANGLE_LO);
        command(CMD_ANGLE_HI);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);
        command(8'(CMD_ANGLE_LO - 1));
        command(8'(CMD_ANGLE_HI + 1));
        command(8'(CMD_STOP - 1));
        command(8'(CMD_STOP + 1));
        command(8'(CMD_START - 1));
        // Switching off while running halts the fan.
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        command(CMD_STOP);
        run_random(180);
        wait_for_replies();

        configure(0, 1023, 375, 0, 1999, 1023);
        run_random(180);
        wait_for_replies();

        // Reversed servo range, and writes to indexes past the register list.
        configure(1023, 0, 380, 1999, 1, 0);
        write_register(3'd6, 11'd2047);
        write_register(3'd7, 11'd0);
        run_random(180);
        wait_for_replies();

        configure(500, 500, 384, $urandom_range(0, 1999), $urandom_range(0, 1999),
                  $urandom_range(0, 1999));
        run_random(120);
        wait_for_replies();

        // Home at zero: the servo has a long way back before the fan can start.
        configure(0, 20, 0, 1199, 799, 399);
        run_random(450);
        wait_for_replies();

        if (board.mismatches == 0 && board.pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
